// ===== src/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants for the cartridge bank mapper
// Bus field widths, address window limits, register codes and the
// structs passed between the mapper stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  // Field widths
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned PHYS_W     = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned LOW_BANK_W = 5;
  localparam int unsigned HIGH_W     = 2;
  localparam int unsigned ROM_BANK_W = LOW_BANK_W + HIGH_W;

  // Bank geometry
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);

  // Register write decoding
  localparam logic [LOW_BANK_W-1:0] LOW_BANK_MASK  = 5'h1F;
  localparam logic [3:0]            RAM_ENABLE_KEY = 4'hA;
  localparam logic [SIZE_W-1:0]     MAX_SIZE_CODE  = 4'd8;

  // Address windows
  localparam logic [ADDR_W-1:0] CART_ROM_END     = 16'h8000;
  localparam logic [ADDR_W-1:0] BOOT_LOW_END     = 16'h0100;
  localparam logic [ADDR_W-1:0] COLOR_BOOT_START = 16'h0200;
  localparam logic [ADDR_W-1:0] COLOR_BOOT_LAST  = 16'h08FF;
  localparam logic [ADDR_W-1:0] RAM_WIN_START    = 16'hA000;
  localparam logic [ADDR_W-1:0] RAM_WIN_LAST     = 16'hBFFF;

  typedef enum logic [2:0] {
    TGT_NONE       = 3'd0,
    TGT_ROM        = 3'd1,
    TGT_RAM        = 3'd2,
    TGT_MONO_BOOT  = 3'd3,
    TGT_COLOR_BOOT = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    MAP_ROM_ONLY   = 2'd0,
    MAP_BANKED     = 2'd1,
    MAP_BANKED_RAM = 2'd2,
    MAP_UNKNOWN    = 2'd3
  } mapper_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAPPER_TYPE   = 2'd0,
    CFG_ROM_SIZE_CODE = 2'd1,
    CFG_COLOR_BOOT    = 2'd2
  } cfg_index_e;

  // Control register window selected by address bits 14:13
  typedef enum logic [1:0] {
    WIN_RAM_ENABLE = 2'd0,
    WIN_LOW_BANK   = 2'd1,
    WIN_HIGH_BITS  = 2'd2,
    WIN_MODE       = 2'd3
  } reg_win_e;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
    logic              boot_rom_active;
  } req_t;

  typedef struct packed {
    target_e           target;
    logic [PHYS_W-1:0] phys_address;
    logic              store_enable;
    logic [DATA_W-1:0] store_data;
  } rsp_t;

  typedef struct packed {
    mapper_e           mapper_type;
    logic [SIZE_W-1:0] rom_size_code;
    logic              color_boot;
  } cfg_t;

  typedef struct packed {
    logic                  ram_on;
    logic                  mode_bit;
    logic [LOW_BANK_W-1:0] low_bank;
    logic [HIGH_W-1:0]     high_bits;
  } bank_t;

  typedef struct packed {
    logic                  set_ram_on;
    logic                  ram_on;
    logic                  set_low_bank;
    logic [LOW_BANK_W-1:0] low_bank;
    logic                  set_high_bits;
    logic [HIGH_W-1:0]     high_bits;
    logic                  set_mode;
    logic                  mode_bit;
  } bank_upd_t;

endpackage

`default_nettype wire

// ===== src/cbm_if.sv =====
// ----------------------------------------------------------------------------
// cbm_if: bus access and mapping result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbm_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [cbm_pkg::ADDR_W-1:0] address;
  logic [cbm_pkg::DATA_W-1:0] write_data;
  logic                      boot_rom_active;

  modport source (output valid, action, address, write_data, boot_rom_active,
                  input ready);
  modport sink   (input valid, action, address, write_data, boot_rom_active,
                  output ready);
endinterface

interface cbm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                target;
  logic [cbm_pkg::PHYS_W-1:0] phys_address;
  logic                      store_enable;
  logic [cbm_pkg::DATA_W-1:0] store_data;

  modport source (output valid, target, phys_address, store_enable, store_data,
                  input ready);
  modport sink   (input valid, target, phys_address, store_enable, store_data,
                  output ready);
endinterface

`default_nettype wire

// ===== src/cbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_bank_regs: configuration and bank control registers
// Holds mapper type, size code and boot layout plus the four bank
// registers; applies register updates from the access decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_bank_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              upd_en_i,
  input  wire cbm_pkg::bank_upd_t                upd_i,
  output cbm_pkg::cfg_t                          cfg_o,
  output cbm_pkg::bank_t                         bank_o
);

  cbm_pkg::cfg_t  cfg_q;
  cbm_pkg::bank_t bank_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mapper_type   <= cbm_pkg::MAP_BANKED;
      cfg_q.rom_size_code <= '0;
      cfg_q.color_boot    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cbm_pkg::CFG_MAPPER_TYPE: begin
          cfg_q.mapper_type <= cbm_pkg::mapper_e'(cfg_data_i[1:0]);
        end
        cbm_pkg::CFG_ROM_SIZE_CODE: begin
          cfg_q.rom_size_code <= cfg_data_i[cbm_pkg::SIZE_W-1:0];
        end
        cbm_pkg::CFG_COLOR_BOOT: begin
          cfg_q.color_boot <= cfg_data_i[0];
        end
        default: ;
      endcase
    end
  end

  // Bank registers; a mapper type write also reloads the RAM enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q.ram_on    <= 1'b0;
      bank_q.mode_bit  <= 1'b0;
      bank_q.low_bank  <= cbm_pkg::LOW_BANK_W'(1);
      bank_q.high_bits <= '0;
    end else if (cfg_we_i && (cfg_index_i == cbm_pkg::CFG_MAPPER_TYPE)) begin
      bank_q.ram_on <= (cfg_data_i[1:0] == cbm_pkg::MAP_BANKED_RAM);
    end else if (upd_en_i) begin
      if (upd_i.set_ram_on)    bank_q.ram_on    <= upd_i.ram_on;
      if (upd_i.set_low_bank)  bank_q.low_bank  <= upd_i.low_bank;
      if (upd_i.set_high_bits) bank_q.high_bits <= upd_i.high_bits;
      if (upd_i.set_mode)      bank_q.mode_bit  <= upd_i.mode_bit;
    end
  end

  assign cfg_o  = cfg_q;
  assign bank_o = bank_q;

  // Zero-to-one forcing keeps the low bank nonzero
  a_low_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_q.low_bank != '0)
    else $error("low bank register holds zero");

  // Access updates load only the register the decoder selects
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_en_i |-> $onehot0({upd_i.set_ram_on, upd_i.set_low_bank,
                           upd_i.set_high_bits, upd_i.set_mode}))
    else $error("more than one bank register updated by one access");

endmodule

`default_nettype wire

// ===== src/cbm_decode.sv =====
// ----------------------------------------------------------------------------
// cbm_decode: access decoder
// Maps one bus access onto ROM, external RAM or a boot overlay, and
// derives the bank register update for control writes below 0x8000.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_decode (
  input  wire cbm_pkg::req_t  req_i,
  input  wire cbm_pkg::cfg_t  cfg_i,
  input  wire cbm_pkg::bank_t bank_i,
  output cbm_pkg::rsp_t       rsp_o,
  output cbm_pkg::bank_upd_t  upd_o
);

  logic                                 wr;
  logic [cbm_pkg::ADDR_W-1:0]           addr;
  logic                                 boot_hit;
  logic                                 in_cart_rom;
  logic                                 in_ram_win;
  logic [cbm_pkg::ROM_BANK_W-1:0]       bank_mask;
  logic [cbm_pkg::ROM_BANK_W-1:0]       full_bank;
  logic [cbm_pkg::ROM_BANK_W-1:0]       sel_bank;
  logic [cbm_pkg::HIGH_W-1:0]           ram_bank;
  logic [cbm_pkg::LOW_BANK_W-1:0]       new_low;
  cbm_pkg::reg_win_e                    win;

  assign wr   = req_i.action;
  assign addr = req_i.address;
  assign win  = cbm_pkg::reg_win_e'(addr[14:13]);

  assign in_cart_rom = addr < cbm_pkg::CART_ROM_END;
  assign in_ram_win  = (addr >= cbm_pkg::RAM_WIN_START) && (addr <= cbm_pkg::RAM_WIN_LAST);

  // Boot overlay window for reads
  always_comb begin
    if (cfg_i.color_boot) begin
      boot_hit = (addr < cbm_pkg::BOOT_LOW_END) ||
                 ((addr >= cbm_pkg::COLOR_BOOT_START) && (addr <= cbm_pkg::COLOR_BOOT_LAST));
    end else begin
      boot_hit = addr < cbm_pkg::BOOT_LOW_END;
    end
  end

  // Bank mask: bits 0..code set; out-of-range codes act as two banks
  always_comb begin
    for (int i = 0; i < cbm_pkg::ROM_BANK_W; i++) begin
      if (cfg_i.rom_size_code > cbm_pkg::MAX_SIZE_CODE) begin
        bank_mask[i] = (i == 0);
      end else begin
        bank_mask[i] = (i == 0) || (cbm_pkg::SIZE_W'(i) <= cfg_i.rom_size_code);
      end
    end
  end

  assign full_bank = {bank_i.high_bits, bank_i.low_bank};

  // ROM bank: switchable window or mode-dependent fixed window
  always_comb begin
    if (addr[14]) begin
      sel_bank = full_bank & bank_mask;
    end else if (bank_i.mode_bit) begin
      sel_bank = {bank_i.high_bits, cbm_pkg::LOW_BANK_W'(0)} & bank_mask;
    end else begin
      sel_bank = '0;
    end
  end

  assign ram_bank = bank_i.mode_bit ? bank_i.high_bits : '0;
  assign new_low  = req_i.write_data[cbm_pkg::LOW_BANK_W-1:0] & cbm_pkg::LOW_BANK_MASK;

  // Result and register update
  always_comb begin
    rsp_o = '0;
    upd_o = '0;
    rsp_o.target = cbm_pkg::TGT_NONE;

    if (req_i.boot_rom_active && wr) begin
      // writes while the boot ROM is mapped are ignored
    end else if (req_i.boot_rom_active && boot_hit) begin
      rsp_o.target       = cfg_i.color_boot ? cbm_pkg::TGT_COLOR_BOOT : cbm_pkg::TGT_MONO_BOOT;
      rsp_o.phys_address = cbm_pkg::PHYS_W'(addr);
    end else begin
      case (cfg_i.mapper_type)
        cbm_pkg::MAP_ROM_ONLY: begin
          if (!wr && in_cart_rom) begin
            rsp_o.target       = cbm_pkg::TGT_ROM;
            rsp_o.phys_address = cbm_pkg::PHYS_W'(addr);
          end
        end
        cbm_pkg::MAP_BANKED, cbm_pkg::MAP_BANKED_RAM: begin
          if (in_cart_rom) begin
            if (wr) begin
              case (win)
                cbm_pkg::WIN_RAM_ENABLE: begin
                  upd_o.set_ram_on = 1'b1;
                  upd_o.ram_on     = (req_i.write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
                end
                cbm_pkg::WIN_LOW_BANK: begin
                  upd_o.set_low_bank = 1'b1;
                  upd_o.low_bank     = (new_low == '0) ? cbm_pkg::LOW_BANK_W'(1) : new_low;
                end
                cbm_pkg::WIN_HIGH_BITS: begin
                  upd_o.set_high_bits = 1'b1;
                  upd_o.high_bits     = req_i.write_data[cbm_pkg::HIGH_W-1:0];
                end
                cbm_pkg::WIN_MODE: begin
                  upd_o.set_mode = 1'b1;
                  upd_o.mode_bit = req_i.write_data[0];
                end
                default: ;
              endcase
            end else begin
              rsp_o.target       = cbm_pkg::TGT_ROM;
              rsp_o.phys_address = {sel_bank, addr[cbm_pkg::ROM_OFS_W-1:0]};
            end
          end else if (in_ram_win && (cfg_i.mapper_type == cbm_pkg::MAP_BANKED_RAM) &&
                       bank_i.ram_on) begin
            rsp_o.target       = cbm_pkg::TGT_RAM;
            rsp_o.phys_address = cbm_pkg::PHYS_W'({ram_bank, addr[cbm_pkg::RAM_OFS_W-1:0]});
            rsp_o.store_enable = wr;
            rsp_o.store_data   = wr ? req_i.write_data : '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cartridge_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: bank controller address translation
// Translates each CPU bus access into a target memory and byte offset,
// and tracks the bank control registers loaded by writes below 0x8000.
//
// Channel   Dir  Payload                                          Transfer
// req       in   action, address, write_data, boot_rom_active     valid & ready
// rsp       out  target, phys_address, store_enable, store_data   valid & ready
// cfg       in   cfg_index_i, cfg_data_i                          cfg_we_i
//
// Each access passes through the input register, then the result
// register; a new access is taken every cycle when rsp is not stalled.
// Bank registers update as an access leaves the input register, so each
// access sees the state left by all earlier ones.
// A stalled result holds; req.ready drops only when both registers are full.
// Reset is asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  cbm_req_if.sink                             req,
  cbm_rsp_if.source                           rsp,
  input  wire logic                           cfg_we_i,
  input  wire logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cbm_pkg::req_t      req_q;
  logic               in_vld_q;
  cbm_pkg::rsp_t      rsp_q;
  cbm_pkg::rsp_t      rsp_d;
  logic               out_vld_q;
  logic               advance;
  cbm_pkg::cfg_t      cfg;
  cbm_pkg::bank_t     bank;
  cbm_pkg::bank_upd_t upd;

  // Pipeline handshake
  assign advance   = in_vld_q && (!out_vld_q || rsp.ready);
  assign req.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q.action          <= req.action;
      req_q.address         <= req.address;
      req_q.write_data      <= req.write_data;
      req_q.boot_rom_active <= req.boot_rom_active;
    end
  end

  cbm_bank_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .upd_en_i    (advance),
    .upd_i       (upd),
    .cfg_o       (cfg),
    .bank_o      (bank)
  );

  cbm_decode u_decode (
    .req_i  (req_q),
    .cfg_i  (cfg),
    .bank_i (bank),
    .rsp_o  (rsp_d),
    .upd_o  (upd)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || rsp.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp.valid        = out_vld_q;
  assign rsp.target       = rsp_q.target;
  assign rsp.phys_address = rsp_q.phys_address;
  assign rsp.store_enable = rsp_q.store_enable;
  assign rsp.store_data   = rsp_q.store_data;

  // Stores go only to external RAM
  a_store_is_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && rsp_q.store_enable) |-> (rsp_q.target == cbm_pkg::TGT_RAM))
    else $error("store enable without RAM target");

  // Ignored accesses carry a zero offset and no store
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (rsp_q.target == cbm_pkg::TGT_NONE)) |->
      (rsp_q.phys_address == '0 && !rsp_q.store_enable))
    else $error("ignored access with nonzero result fields");

  // An empty input register always takes a transfer
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> req.ready)
    else $error("input stalled while input register empty");

  // An access never leaves the input register into a stalled result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp.ready) |-> !advance)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== verif/cartridge_bank_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_tb: self-checking bench for the bank mapper
// Drives bus accesses on the request channel, predicts each mapping result
// from a local copy of the bank and mapper registers, and compares every
// result transfer against the oldest prediction. Runs through a sequence of
// mapper settings, including the extremes and the undefined codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cartridge_bank_mapper_tb;

  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned RAND_PER_PHASE = 148;
  localparam int unsigned HOLD_CYCLES    = 100;
  localparam int unsigned NUM_SETTINGS   = 13;

  typedef struct {
    cbm_pkg::mapper_e           mtype;
    logic [cbm_pkg::SIZE_W-1:0] size_code;
    logic                       color;
  } setting_t;

  // Mapper settings visited by the random phases
  setting_t setting_plan [NUM_SETTINGS] = '{
    '{cbm_pkg::MAP_BANKED_RAM, 4'd8,  1'b1},
    '{cbm_pkg::MAP_BANKED_RAM, 4'd0,  1'b0},
    '{cbm_pkg::MAP_BANKED,     4'd5,  1'b0},
    '{cbm_pkg::MAP_ROM_ONLY,   4'd3,  1'b1},
    '{cbm_pkg::MAP_BANKED_RAM, 4'd4,  1'b1},
    '{cbm_pkg::MAP_UNKNOWN,    4'd2,  1'b1},
    '{cbm_pkg::MAP_BANKED,     4'd8,  1'b1},
    '{cbm_pkg::MAP_BANKED_RAM, 4'd12, 1'b0},
    '{cbm_pkg::MAP_ROM_ONLY,   4'd0,  1'b0},
    '{cbm_pkg::MAP_BANKED_RAM, 4'd6,  1'b0},
    '{cbm_pkg::MAP_BANKED,     4'd15, 1'b1},
    '{cbm_pkg::MAP_UNKNOWN,    4'd9,  1'b0},
    '{cbm_pkg::MAP_BANKED_RAM, 4'd8,  1'b0}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data;

  cbm_req_if req_ch ();
  cbm_rsp_if rsp_ch ();

  cartridge_bank_mapper dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Local copy of configuration and bank state
  cbm_pkg::mapper_e           cfg_type;
  logic [cbm_pkg::SIZE_W-1:0] cfg_size;
  logic                       cfg_color;
  cbm_pkg::bank_t             bank_state;

  cbm_pkg::req_t access_q [$];
  cbm_pkg::rsp_t mapping_q [$];

  int unsigned cycle_cnt;
  int unsigned error_cnt;
  int unsigned issued_cnt;
  int unsigned checked_cnt;
  int unsigned setting_cnt;
  logic        req_taken;
  logic        no_idle;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;

  always #6 clk = ~clk;

  // Translate one access and advance the bank registers
  function automatic cbm_pkg::rsp_t map_access(cbm_pkg::req_t a);
    cbm_pkg::rsp_t r;
    int unsigned   code;
    int unsigned   mask;
    int unsigned   bank;
    int unsigned   phys;
    r = '0;
    r.target = cbm_pkg::TGT_NONE;
    if (a.boot_rom_active) begin
      if (a.action) return r;
      if (cfg_color) begin
        if (a.address < cbm_pkg::BOOT_LOW_END ||
            (a.address >= cbm_pkg::COLOR_BOOT_START &&
             a.address <= cbm_pkg::COLOR_BOOT_LAST)) begin
          r.target = cbm_pkg::TGT_COLOR_BOOT;
          r.phys_address = cbm_pkg::PHYS_W'(a.address);
          return r;
        end
      end else if (a.address < cbm_pkg::BOOT_LOW_END) begin
        r.target = cbm_pkg::TGT_MONO_BOOT;
        r.phys_address = cbm_pkg::PHYS_W'(a.address);
        return r;
      end
    end
    if (cfg_type == cbm_pkg::MAP_ROM_ONLY) begin
      if (!a.action && a.address < cbm_pkg::CART_ROM_END) begin
        r.target = cbm_pkg::TGT_ROM;
        r.phys_address = cbm_pkg::PHYS_W'(a.address);
      end
      return r;
    end
    if (cfg_type == cbm_pkg::MAP_UNKNOWN) return r;

    if (a.address < cbm_pkg::CART_ROM_END) begin
      if (a.action) begin
        // control register window picked by address bits 14:13
        case (cbm_pkg::reg_win_e'(a.address[14:13]))
          cbm_pkg::WIN_RAM_ENABLE:
            bank_state.ram_on = (a.write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
          cbm_pkg::WIN_LOW_BANK: begin
            bank_state.low_bank = a.write_data[cbm_pkg::LOW_BANK_W-1:0] &
                                  cbm_pkg::LOW_BANK_MASK;
            if (bank_state.low_bank == '0) bank_state.low_bank = cbm_pkg::LOW_BANK_W'(1);
          end
          cbm_pkg::WIN_HIGH_BITS:
            bank_state.high_bits = a.write_data[cbm_pkg::HIGH_W-1:0];
          default: bank_state.mode_bit = a.write_data[0];
        endcase
      end else begin
        code = (cfg_size > cbm_pkg::MAX_SIZE_CODE) ? 0 : cfg_size;
        mask = (2 << code) - 1;
        if (a.address[14])
          bank = {bank_state.high_bits, bank_state.low_bank} & mask;
        else
          bank = bank_state.mode_bit ?
                 ((bank_state.high_bits << cbm_pkg::LOW_BANK_W) & mask) : 0;
        phys = bank * cbm_pkg::ROM_BANK_BYTES +
               (a.address & (cbm_pkg::ROM_BANK_BYTES - 1));
        r.target = cbm_pkg::TGT_ROM;
        r.phys_address = cbm_pkg::PHYS_W'(phys);
      end
      return r;
    end

    if (a.address >= cbm_pkg::RAM_WIN_START && a.address <= cbm_pkg::RAM_WIN_LAST &&
        cfg_type == cbm_pkg::MAP_BANKED_RAM && bank_state.ram_on) begin
      bank = bank_state.mode_bit ? bank_state.high_bits : 0;
      phys = bank * cbm_pkg::RAM_BANK_BYTES + (a.address - cbm_pkg::RAM_WIN_START);
      r.target = cbm_pkg::TGT_RAM;
      r.phys_address = cbm_pkg::PHYS_W'(phys);
      r.store_enable = a.action;
      r.store_data = a.action ? a.write_data : '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    error_cnt++;
  endtask

  // Request driver: new payload at the falling edge once the last one transferred
  always @(negedge clk) begin : req_driver
    cbm_pkg::req_t nxt;
    if (rst_n && (!req_ch.valid || req_taken)) begin
      if (access_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 18)) begin
        nxt = access_q.pop_front();
        issued_cnt++;
        req_ch.action          <= nxt.action;
        req_ch.address         <= nxt.address;
        req_ch.write_data      <= nxt.write_data;
        req_ch.boot_rom_active <= nxt.boot_rom_active;
        req_ch.valid           <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus long hold-offs on request
  always @(negedge clk) begin : rsp_acceptor
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 18);
    end
  end

  // Monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin : monitor
    cbm_pkg::req_t seen;
    cbm_pkg::rsp_t want;
    req_taken = 1'b0;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("FAILED: results differ");
        $finish;
      end else begin
        if (req_ch.valid && req_ch.ready) begin
          req_taken = 1'b1;
          seen.action          = req_ch.action;
          seen.address         = req_ch.address;
          seen.write_data      = req_ch.write_data;
          seen.boot_rom_active = req_ch.boot_rom_active;
          mapping_q.push_back(map_access(seen));
        end
        if (rsp_ch.valid && rsp_ch.ready) begin
          checked_cnt++;
          if (mapping_q.size() == 0) begin
            report_mismatch("result transfer with no access outstanding");
          end else begin
            want = mapping_q.pop_front();
            if (rsp_ch.target !== want.target)
              report_mismatch($sformatf("target got %0d want %0d",
                                        rsp_ch.target, want.target));
            if (rsp_ch.phys_address !== want.phys_address)
              report_mismatch($sformatf("phys_address got %h want %h",
                                        rsp_ch.phys_address, want.phys_address));
            if (rsp_ch.store_enable !== want.store_enable)
              report_mismatch($sformatf("store_enable got %b want %b",
                                        rsp_ch.store_enable, want.store_enable));
            if (rsp_ch.store_data !== want.store_data)
              report_mismatch($sformatf("store_data got %h want %h",
                                        rsp_ch.store_data, want.store_data));
          end
        end
      end
    end
  end

  task automatic queue_access(logic act, logic [cbm_pkg::ADDR_W-1:0] addr,
                              logic [cbm_pkg::DATA_W-1:0] data, logic boot);
    cbm_pkg::req_t a;
    a.action          = act;
    a.address         = addr;
    a.write_data      = data;
    a.boot_rom_active = boot;
    access_q.push_back(a);
  endtask

  // Mostly well-formed traffic: register loads, ROM reads, RAM window, boot window
  function automatic cbm_pkg::req_t random_access();
    cbm_pkg::req_t a;
    int unsigned   pick;
    a.action          = 1'($urandom_range(0, 1));
    a.address         = 16'($urandom);
    a.write_data      = 8'($urandom);
    a.boot_rom_active = ($urandom_range(0, 99) < 8);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      a.action  = 1'b1;
      a.address = 16'($urandom_range(0, cbm_pkg::CART_ROM_END - 1));
      if (a.address[14:13] == cbm_pkg::WIN_RAM_ENABLE && $urandom_range(0, 1))
        a.write_data[3:0] = cbm_pkg::RAM_ENABLE_KEY;
    end else if (pick < 58) begin
      a.action  = 1'b0;
      a.address = 16'($urandom_range(0, cbm_pkg::CART_ROM_END - 1));
    end else if (pick < 80) begin
      a.address = 16'($urandom_range(cbm_pkg::RAM_WIN_START, cbm_pkg::RAM_WIN_LAST));
    end else if (pick < 88) begin
      a.action          = 1'b0;
      a.boot_rom_active = 1'b1;
      a.address         = 16'($urandom_range(0, 16'h0FFF));
    end
    // remaining picks stay fully random across the bus
    return a;
  endfunction

  task automatic write_register(cbm_pkg::cfg_index_e idx,
                                logic [cbm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      cbm_pkg::CFG_MAPPER_TYPE: begin
        cfg_type = cbm_pkg::mapper_e'(val[1:0]);
        bank_state.ram_on = (cfg_type == cbm_pkg::MAP_BANKED_RAM);
      end
      cbm_pkg::CFG_ROM_SIZE_CODE: cfg_size = val;
      default:                    cfg_color = val[0];
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    write_register(cbm_pkg::CFG_MAPPER_TYPE, cbm_pkg::CFG_DATA_W'(s.mtype));
    write_register(cbm_pkg::CFG_ROM_SIZE_CODE, s.size_code);
    write_register(cbm_pkg::CFG_COLOR_BOOT, cbm_pkg::CFG_DATA_W'(s.color));
    setting_cnt++;
  endtask

  // Block until every queued access has produced its result
  task automatic wait_idle();
    while (access_q.size() != 0 || issued_cnt != checked_cnt || mapping_q.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = cbm_pkg::CFG_MAPPER_TYPE;
    cfg_data    = '0;
    no_idle     = 1'b0;
    hold_reqs   = 0;
    hold_seen   = 0;
    hold_left   = 0;
    cycle_cnt   = 0;
    error_cnt   = 0;
    issued_cnt  = 0;
    checked_cnt = 0;
    setting_cnt = 1;
    req_taken   = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.action          = 1'b0;
    req_ch.address         = '0;
    req_ch.write_data      = '0;
    req_ch.boot_rom_active = 1'b0;
    rsp_ch.ready           = 1'b0;
    cfg_type   = cbm_pkg::MAP_BANKED;
    cfg_size   = '0;
    cfg_color  = 1'b0;
    bank_state = '{ram_on: 1'b0, mode_bit: 1'b0, low_bank: 5'd1, high_bits: 2'd0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: banked without RAM, two banks
    queue_access(1'b0, 16'h4000, 8'h00, 1'b0);
    queue_access(1'b1, 16'hA000, 8'h5A, 1'b0);
    queue_access(1'b0, 16'h0000, 8'h00, 1'b0);
    wait_idle();

    // directed: boot overlay edges, zero forcing, largest bank, RAM enable key
    apply_setting('{cbm_pkg::MAP_BANKED_RAM, 4'd8, 1'b1});
    queue_access(1'b0, 16'h00FF, 8'h00, 1'b1);
    queue_access(1'b0, 16'h0100, 8'hFF, 1'b1);
    queue_access(1'b0, 16'h0200, 8'h00, 1'b1);
    queue_access(1'b0, 16'h08FF, 8'h00, 1'b1);
    queue_access(1'b0, 16'h0900, 8'h00, 1'b1);
    queue_access(1'b1, 16'h2000, 8'hFF, 1'b1);
    queue_access(1'b1, 16'h2000, 8'h00, 1'b0);
    queue_access(1'b0, 16'h4000, 8'h00, 1'b0);
    queue_access(1'b1, 16'h3FFF, 8'hFF, 1'b0);
    queue_access(1'b1, 16'h4000, 8'hFF, 1'b0);
    queue_access(1'b0, 16'h7FFF, 8'h00, 1'b0);
    queue_access(1'b0, 16'h0000, 8'h00, 1'b0);
    queue_access(1'b1, 16'h6000, 8'h01, 1'b0);
    queue_access(1'b0, 16'h3FFF, 8'h00, 1'b0);
    queue_access(1'b1, 16'hBFFF, 8'hFF, 1'b0);
    queue_access(1'b0, 16'hA000, 8'hFF, 1'b0);
    queue_access(1'b1, 16'h0000, 8'h1B, 1'b0);
    queue_access(1'b0, 16'hA000, 8'h00, 1'b0);
    queue_access(1'b1, 16'h1FFF, 8'hFA, 1'b0);
    queue_access(1'b1, 16'hA000, 8'h00, 1'b0);
    queue_access(1'b0, 16'h8000, 8'h00, 1'b0);
    queue_access(1'b1, 16'hFFFF, 8'hFF, 1'b0);
    queue_access(1'b0, 16'hC000, 8'h00, 1'b1);
    queue_access(1'b1, 16'h7FFF, 8'hFE, 1'b0);
    wait_idle();

    // random phases, one per mapper setting
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      apply_setting(setting_plan[p]);
      no_idle = (p == 2);
      if (p == 7) begin
        // sender pauses mid-phase until the pipeline drains
        for (int k = 0; k < RAND_PER_PHASE / 2; k++) access_q.push_back(random_access());
        wait_idle();
        for (int k = RAND_PER_PHASE / 2; k < RAND_PER_PHASE; k++)
          access_q.push_back(random_access());
      end else begin
        for (int k = 0; k < RAND_PER_PHASE; k++) access_q.push_back(random_access());
      end
      // long result hold-off while requests keep coming
      if (p == 4) hold_reqs++;
      wait_idle();
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (4) @(negedge clk);
    if (mapping_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", mapping_q.size()));
    $display("Summary: %0d accesses over %0d mapper settings, %0d results checked",
             issued_cnt, setting_cnt, checked_cnt);
    $display("Covered boot overlays, ROM banking, RAM banking and undefined codes");
    if (error_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
